// ===== rtl/core/mpm_pkg.sv =====
// Shared types, constants and register codes of the pulse power monitor.
// No dependencies; mpm_cfg_regs, mpm_serial_div, the top level and the bench import this package.
`default_nettype none
package mpm_pkg;

    localparam int MPM_TIME_BITS = 32;
    localparam int MPM_SUM_W     = 48;
    localparam int MPM_OUT_W     = 32;
    localparam int MPM_NUM_W     = 40;
    localparam int MPM_CFG_W     = 40;
    localparam int MPM_CFG_IDX_W = 3;
    localparam int MPM_WCNT_W    = 16;

    localparam logic [MPM_CFG_IDX_W-1:0] CFG_MIN_INTERVAL    = 3'd0;
    localparam logic [MPM_CFG_IDX_W-1:0] CFG_REPORT_INTERVAL = 3'd1;
    localparam logic [MPM_CFG_IDX_W-1:0] CFG_LIVE_NUMERATOR  = 3'd2;
    localparam logic [MPM_CFG_IDX_W-1:0] CFG_AVG_NUMERATOR   = 3'd3;

    localparam logic [31:0]          RST_MIN_INTERVAL    = 32'd50000;
    localparam logic [31:0]          RST_REPORT_INTERVAL = 32'd30000000;
    localparam logic [MPM_NUM_W-1:0] RST_LIVE_NUMERATOR  = 40'd3060000000;
    localparam logic [MPM_NUM_W-1:0] RST_AVG_NUMERATOR   = 40'd3600000000;

    typedef struct packed {
        logic [31:0]          min_interval;
        logic [31:0]          report_interval;
        logic [MPM_NUM_W-1:0] live_numerator;
        logic [MPM_NUM_W-1:0] avg_numerator;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [MPM_SUM_W-1:0] add_sat48(input logic [MPM_SUM_W-1:0] a,
                                                       input logic [MPM_SUM_W-1:0] b);
        logic [MPM_SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[MPM_SUM_W] ? {MPM_SUM_W{1'b1}} : s[MPM_SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mpm_ifs.sv =====
// Valid/ready channel interfaces: pulse samples in, meter results out.
// No dependencies.
`default_nettype none
interface mpm_pulse_if;
    logic valid;
    logic ready;
    logic pulse_level;

    modport source (output valid, output pulse_level, input ready);
    modport sink   (input valid, input pulse_level, output ready);
endinterface

interface mpm_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] live_power_w;
    logic [31:0] blink_total;
    logic [31:0] interval_ticks;
    logic        report_valid;
    logic [15:0] report_blinks;
    logic [31:0] avg_interval_ticks;
    logic [31:0] avg_power_w;

    modport source (output valid, output live_power_w, output blink_total,
                    output interval_ticks, output report_valid, output report_blinks,
                    output avg_interval_ticks, output avg_power_w, input ready);
    modport sink   (input valid, input live_power_w, input blink_total,
                    input interval_ticks, input report_valid, input report_blinks,
                    input avg_interval_ticks, input avg_power_w, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mpm_cfg_regs.sv =====
// Configuration register file of the pulse power monitor.
// Depends on mpm_pkg for register codes, reset values and cfg_t.
`default_nettype none
module mpm_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [mpm_pkg::MPM_CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mpm_pkg::MPM_CFG_W-1:0]     cfg_data,
    output mpm_pkg::cfg_t                          cfg
);
    import mpm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_INTERVAL:    cfg_next.min_interval    = cfg_data[31:0];
                CFG_REPORT_INTERVAL: cfg_next.report_interval = cfg_data[31:0];
                CFG_LIVE_NUMERATOR:  cfg_next.live_numerator  = cfg_data[MPM_NUM_W-1:0];
                CFG_AVG_NUMERATOR:   cfg_next.avg_numerator   = cfg_data[MPM_NUM_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_interval    <= RST_MIN_INTERVAL;
            cfg_reg.report_interval <= RST_REPORT_INTERVAL;
            cfg_reg.live_numerator  <= RST_LIVE_NUMERATOR;
            cfg_reg.avg_numerator   <= RST_AVG_NUMERATOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mpm_serial_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, quotient saturated
// to 32 bits and all ones for a zero divisor. Depends on mpm_pkg.
`default_nettype none
module mpm_serial_div #(
    parameter int W = mpm_pkg::MPM_SUM_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [W-1:0]                  dividend,
    input  wire logic [W-1:0]                  divisor,
    output mpm_pkg::div_stat_t                 stat,
    output logic [mpm_pkg::MPM_OUT_W-1:0]      quotient
);
    import mpm_pkg::*;

    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] LAST = CW'(W - 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // restore when the trial subtract borrows
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    always_comb
    begin
        if (den_reg == '0 || quo_reg[W-1:MPM_OUT_W] != '0)
        begin
            quotient = '1;
        end
        else
        begin
            quotient = quo_reg[MPM_OUT_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

// ===== rtl/core/meter_pulse_power_monitor.sv =====
// Pulse power monitor top level: edge timing, window sums, result sequencing.
// Depends on mpm_pkg, mpm_ifs, mpm_cfg_regs and mpm_serial_div.
//
// Each sample transfer is one timer tick. A tick without a rising edge stays in
// S_IDLE; a rising edge is checked in S_CHECK and, if rejected as a glitch, goes
// back to S_IDLE. An accepted edge runs its quotients through one shared
// bit-serial divider that resolves one quotient bit per cycle over 48 bits: two
// quotients (live and per-blink power) without a report, four with a report, and
// then loads the result register in S_OUT. Samples are taken again as soon as
// the result is loaded, while it waits to be transferred out.
`default_nettype none
module meter_pulse_power_monitor #(
    parameter int TIME_BITS = mpm_pkg::MPM_TIME_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [mpm_pkg::MPM_CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mpm_pkg::MPM_CFG_W-1:0]     cfg_data,
    mpm_pulse_if.sink                              samples,
    mpm_result_if.source                           results
);
    import mpm_pkg::*;

    localparam int CMP_W = (TIME_BITS > MPM_OUT_W) ? TIME_BITS : MPM_OUT_W;
    localparam logic [CMP_W-1:0] MAX_OUT = CMP_W'({MPM_OUT_W{1'b1}});

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_DIV_LIVE = 3'd2;
    localparam logic [2:0] S_DIV_AVGP = 3'd3;
    localparam logic [2:0] S_DIV_AVGI = 3'd4;
    localparam logic [2:0] S_DIV_AVGW = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    cfg_t      cfg;
    div_stat_t div_stat;
    logic                 div_start;
    logic [MPM_SUM_W-1:0] div_dividend;
    logic [MPM_SUM_W-1:0] div_divisor;
    logic [MPM_OUT_W-1:0] div_quotient;

    logic [2:0]            state_reg, state_next;
    logic                  prev_level_reg, prev_level_next;
    logic [TIME_BITS-1:0]  tick_reg, tick_next;
    logic [TIME_BITS-1:0]  last_edge_reg, last_edge_next;
    logic [TIME_BITS-1:0]  last_report_reg, last_report_next;
    logic [TIME_BITS-1:0]  edge_time_reg, edge_time_next;
    logic [TIME_BITS-1:0]  interval_reg, interval_next;
    logic [TIME_BITS-1:0]  elapsed_reg, elapsed_next;
    logic [31:0]           blinks_reg, blinks_next;
    logic [MPM_WCNT_W-1:0] wcount_reg, wcount_next;
    logic [MPM_SUM_W-1:0]  isum_reg, isum_next;
    logic [MPM_SUM_W-1:0]  psum_reg, psum_next;
    logic                  report_reg, report_next;
    logic [MPM_WCNT_W-1:0] rep_blinks_reg, rep_blinks_next;
    logic [MPM_OUT_W-1:0]  live_reg, live_next;
    logic [MPM_OUT_W-1:0]  avg_i_reg, avg_i_next;
    logic [MPM_OUT_W-1:0]  avg_p_reg, avg_p_next;

    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           o_live_reg, o_live_next;
    logic [31:0]           o_blinks_reg, o_blinks_next;
    logic [31:0]           o_interval_reg, o_interval_next;
    logic                  o_report_reg, o_report_next;
    logic [15:0]           o_rep_blinks_reg, o_rep_blinks_next;
    logic [31:0]           o_avg_i_reg, o_avg_i_next;
    logic [31:0]           o_avg_p_reg, o_avg_p_next;

    logic                  accept;
    logic                  out_free;
    logic [MPM_WCNT_W-1:0] wcount_inc;

    mpm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpm_serial_div #(
        .W (MPM_SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign out_free      = !out_valid_reg || results.ready;
    assign wcount_inc    = (wcount_reg == '1) ? wcount_reg : wcount_reg + 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        prev_level_next  = prev_level_reg;
        tick_next        = tick_reg;
        last_edge_next   = last_edge_reg;
        last_report_next = last_report_reg;
        edge_time_next   = edge_time_reg;
        interval_next    = interval_reg;
        elapsed_next     = elapsed_reg;
        blinks_next      = blinks_reg;
        wcount_next      = wcount_reg;
        isum_next        = isum_reg;
        psum_next        = psum_reg;
        report_next      = report_reg;
        rep_blinks_next  = rep_blinks_reg;
        live_next        = live_reg;
        avg_i_next       = avg_i_reg;
        avg_p_next       = avg_p_reg;
        div_start        = 1'b0;
        div_dividend     = MPM_SUM_W'(cfg.live_numerator);
        div_divisor      = MPM_SUM_W'(interval_reg);

        o_live_next       = o_live_reg;
        o_blinks_next     = o_blinks_reg;
        o_interval_next   = o_interval_reg;
        o_report_next     = o_report_reg;
        o_rep_blinks_next = o_rep_blinks_reg;
        o_avg_i_next      = o_avg_i_reg;
        o_avg_p_next      = o_avg_p_reg;
        out_valid_next    = (out_valid_reg && results.ready) ? 1'b0 : out_valid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    prev_level_next = samples.pulse_level;
                    tick_next       = tick_reg + 1'b1;
                    if (samples.pulse_level && !prev_level_reg)
                    begin
                        interval_next  = tick_reg - last_edge_reg;
                        elapsed_next   = tick_reg - last_report_reg;
                        last_edge_next = tick_reg;
                        edge_time_next = tick_reg;
                        state_next     = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (CMP_W'(interval_reg) < CMP_W'(cfg.min_interval))
                begin
                    // glitch: timing already restarted from this edge
                    state_next = S_IDLE;
                end
                else
                begin
                    blinks_next     = blinks_reg + 1'b1;
                    wcount_next     = wcount_inc;
                    isum_next       = add_sat48(isum_reg, MPM_SUM_W'(interval_reg));
                    report_next     = CMP_W'(elapsed_reg) > CMP_W'(cfg.report_interval);
                    rep_blinks_next = report_next ? wcount_inc : '0;
                    avg_i_next      = '0;
                    avg_p_next      = '0;
                    div_start       = 1'b1;
                    state_next      = S_DIV_LIVE;
                end
            end
            S_DIV_LIVE:
            begin
                if (div_stat.done)
                begin
                    live_next    = div_quotient;
                    div_start    = 1'b1;
                    div_dividend = MPM_SUM_W'(cfg.avg_numerator);
                    state_next   = S_DIV_AVGP;
                end
            end
            S_DIV_AVGP:
            begin
                if (div_stat.done)
                begin
                    psum_next = add_sat48(psum_reg, MPM_SUM_W'(div_quotient));
                    if (report_reg)
                    begin
                        div_start    = 1'b1;
                        div_dividend = isum_reg;
                        div_divisor  = MPM_SUM_W'(wcount_reg);
                        state_next   = S_DIV_AVGI;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DIV_AVGI:
            begin
                if (div_stat.done)
                begin
                    avg_i_next   = div_quotient;
                    div_start    = 1'b1;
                    div_dividend = psum_reg;
                    div_divisor  = MPM_SUM_W'(wcount_reg);
                    state_next   = S_DIV_AVGW;
                end
            end
            S_DIV_AVGW:
            begin
                if (div_stat.done)
                begin
                    avg_p_next       = div_quotient;
                    last_report_next = edge_time_reg;
                    wcount_next      = '0;
                    isum_next        = '0;
                    psum_next        = '0;
                    state_next       = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the result register is free
                if (out_free)
                begin
                    o_live_next       = live_reg;
                    o_blinks_next     = blinks_reg;
                    o_interval_next   = (CMP_W'(interval_reg) > MAX_OUT) ?
                                        '1 : MPM_OUT_W'(CMP_W'(interval_reg));
                    o_report_next     = report_reg;
                    o_rep_blinks_next = rep_blinks_reg;
                    o_avg_i_next      = avg_i_reg;
                    o_avg_p_next      = avg_p_reg;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            prev_level_reg  <= 1'b0;
            tick_reg        <= '0;
            last_edge_reg   <= '0;
            last_report_reg <= '0;
            blinks_reg      <= '0;
            wcount_reg      <= '0;
            isum_reg        <= '0;
            psum_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            prev_level_reg  <= prev_level_next;
            tick_reg        <= tick_next;
            last_edge_reg   <= last_edge_next;
            last_report_reg <= last_report_next;
            blinks_reg      <= blinks_next;
            wcount_reg      <= wcount_next;
            isum_reg        <= isum_next;
            psum_reg        <= psum_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_time_reg    <= edge_time_next;
        interval_reg     <= interval_next;
        elapsed_reg      <= elapsed_next;
        report_reg       <= report_next;
        rep_blinks_reg   <= rep_blinks_next;
        live_reg         <= live_next;
        avg_i_reg        <= avg_i_next;
        avg_p_reg        <= avg_p_next;
        o_live_reg       <= o_live_next;
        o_blinks_reg     <= o_blinks_next;
        o_interval_reg   <= o_interval_next;
        o_report_reg     <= o_report_next;
        o_rep_blinks_reg <= o_rep_blinks_next;
        o_avg_i_reg      <= o_avg_i_next;
        o_avg_p_reg      <= o_avg_p_next;
    end

    assign results.valid              = out_valid_reg;
    assign results.live_power_w       = o_live_reg;
    assign results.blink_total        = o_blinks_reg;
    assign results.interval_ticks     = o_interval_reg;
    assign results.report_valid       = o_report_reg;
    assign results.report_blinks      = o_rep_blinks_reg;
    assign results.avg_interval_ticks = o_avg_i_reg;
    assign results.avg_power_w        = o_avg_p_reg;

endmodule
`default_nettype wire

// ===== tb/meter_pulse_power_monitor_tb.sv =====
// Self-checking bench for the pulse power monitor: random timer ticks in, meter results out.
// Depends on mpm_pkg, the mpm_ifs channel interfaces and meter_pulse_power_monitor.
`default_nettype none
module meter_pulse_power_monitor_tb;
    import mpm_pkg::*;

    localparam int          IDLE_PCT      = 32;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 400;
    localparam int unsigned RANDOM_TICKS  = 1550;
    localparam logic [31:0] LIMIT_CYCLES  = 32'd2_000_000;

    localparam logic [MPM_CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd4;

    typedef enum logic [1:0] {ACT_TICK, ACT_PAUSE, ACT_WRITE} act_kind_e;

    typedef struct packed {
        act_kind_e                kind;
        logic                     level;
        logic [MPM_CFG_IDX_W-1:0] idx;
        logic [MPM_CFG_W-1:0]     data;
    } feed_entry_t;

    typedef struct packed {
        logic [31:0] live_w;
        logic [31:0] total;
        logic [31:0] ivl;
        logic        rpt;
        logic [15:0] rpt_blinks;
        logic [31:0] avg_ivl;
        logic [31:0] avg_w;
    } reading_t;

    typedef enum int {
        SET_EVERY_EDGE, SET_ALL_GLITCH, SET_NO_REPORT, SET_ZERO_REPORT,
        SET_MIXED, SET_WIDE, SET_STRAY_INDEX
    } setting_e;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [MPM_CFG_IDX_W-1:0] cfg_index = '0;
    logic [MPM_CFG_W-1:0]     cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_level = 1'b0;
    logic                     out_ready = 1'b0;
    logic                     feed_done = 1'b0;
    logic                     readings_owed = 1'b0;
    logic [31:0]              cycle_cnt = '0;
    logic                     steady;
    int unsigned              mismatch_cnt = 0;

    feed_entry_t feed_q[$];
    reading_t    pending_readings[$];

    // meter model: configuration and state
    logic [31:0]          min_ivl, rpt_ivl;
    logic [MPM_NUM_W-1:0] live_num, avg_num;
    logic                 prev_lvl;
    logic [31:0]          tick_now, last_edge, last_rpt, blink_cnt;
    logic [15:0]          win_cnt;
    logic [47:0]          win_ivl_sum, win_pwr_sum;

    // driver-side sequencing
    logic draining = 1'b0;
    int   settle = 0;

    mpm_pulse_if  samples_if ();
    mpm_result_if results_if ();

    assign samples_if.valid       = in_valid;
    assign samples_if.pulse_level = in_level;
    assign results_if.ready       = out_ready;

    // no idling on either side in one stretch of every four
    assign steady = (cycle_cnt[13:12] == 2'b11);

    meter_pulse_power_monitor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_if),
        .results   (results_if)
    );

    function automatic logic [31:0] quot_sat(input logic [47:0] num, input logic [47:0] den);
        logic [47:0] q;
        if (den == '0)
            return '1;
        q = num / den;
        return (q > 48'hFFFF_FFFF) ? '1 : q[31:0];
    endfunction

    function automatic logic [47:0] sum_sat(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

    function automatic logic [MPM_NUM_W-1:0] pick_numerator();
        logic [MPM_NUM_W-1:0] v;
        case ($urandom_range(4))
            0:       v = 40'd1;
            1:       v = '1;
            2:       v = {8'($urandom), 32'($urandom)};
            3:       v = 40'($urandom_range(1, 100000));
            default: v = RST_LIVE_NUMERATOR;
        endcase
        return v;
    endfunction

    task automatic meter_tick(input logic lvl);
        logic [31:0] t_now;
        logic [31:0] ivl;
        reading_t    r;
        t_now    = tick_now;
        tick_now = tick_now + 32'd1;
        if (lvl && !prev_lvl)
        begin
            ivl       = t_now - last_edge;
            last_edge = t_now;
            // a glitch only restarts the interval
            if (ivl >= min_ivl)
            begin
                blink_cnt = blink_cnt + 32'd1;
                if (win_cnt != 16'hFFFF)
                    win_cnt = win_cnt + 16'd1;
                win_ivl_sum = sum_sat(win_ivl_sum, {16'd0, ivl});
                win_pwr_sum = sum_sat(win_pwr_sum, {16'd0, quot_sat({8'd0, avg_num}, {16'd0, ivl})});
                r        = '0;
                r.live_w = quot_sat({8'd0, live_num}, {16'd0, ivl});
                r.total  = blink_cnt;
                r.ivl    = ivl;
                if ((t_now - last_rpt) > rpt_ivl)
                begin
                    r.rpt        = 1'b1;
                    r.rpt_blinks = win_cnt;
                    r.avg_ivl    = quot_sat(win_ivl_sum, {32'd0, win_cnt});
                    r.avg_w      = quot_sat(win_pwr_sum, {32'd0, win_cnt});
                    last_rpt     = t_now;
                    win_cnt      = '0;
                    win_ivl_sum  = '0;
                    win_pwr_sum  = '0;
                end
                pending_readings.push_back(r);
            end
        end
        prev_lvl = lvl;
    endtask

    task automatic flag_reading(input string what, input reading_t want, input reading_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
        begin
            $display("%s at cycle %0d", what, cycle_cnt);
            $display("  expected live %0d total %0d interval %0d report %0b/%0d avg %0d %0d",
                     want.live_w, want.total, want.ivl, want.rpt, want.rpt_blinks,
                     want.avg_ivl, want.avg_w);
            $display("  actual   live %0d total %0d interval %0d report %0b/%0d avg %0d %0d",
                     got.live_w, got.total, got.ivl, got.rpt, got.rpt_blinks,
                     got.avg_ivl, got.avg_w);
        end
    endtask

    task automatic push_tick(input logic lvl);
        feed_q.push_back('{kind: ACT_TICK, level: lvl, idx: '0, data: '0});
    endtask

    task automatic push_pause();
        feed_q.push_back('{kind: ACT_PAUSE, level: 1'b0, idx: '0, data: '0});
    endtask

    task automatic push_write(input logic [MPM_CFG_IDX_W-1:0] idx, input logic [MPM_CFG_W-1:0] data);
        feed_q.push_back('{kind: ACT_WRITE, level: 1'b0, idx: idx, data: data});
    endtask

    task automatic push_pulse(input int unsigned lo, input int unsigned hi);
        repeat (lo) push_tick(1'b0);
        repeat (hi) push_tick(1'b1);
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin : stimulus
        int unsigned          fed, n, phase_no, phase_len, sel, lo, hi;
        setting_e             mode;
        logic [31:0]          min_v, rpt_v;
        logic [MPM_NUM_W-1:0] live_v, avg_v;

        // zero interval on the very first edge, saturated live power, report boundary
        push_pause();
        push_write(CFG_MIN_INTERVAL, {8'hA5, 32'd0});
        push_write(CFG_REPORT_INTERVAL, {8'h5A, 32'd3});
        push_write(CFG_LIVE_NUMERATOR, '1);
        push_write(CFG_AVG_NUMERATOR, 40'd1);
        push_tick(1'b1);
        push_pulse(1, 1);
        push_pulse(3, 2);
        push_pulse(1, 1);
        push_pulse(1, 1);
        // glitches restart the interval; an interval equal to the minimum passes
        push_pause();
        push_write(CFG_MIN_INTERVAL, 40'd4);
        push_write(CFG_REPORT_INTERVAL, 40'd10);
        push_write(CFG_LIVE_NUMERATOR, 40'd1000);
        push_write(CFG_AVG_NUMERATOR, 40'd3600);
        push_pulse(2, 1);
        push_pulse(3, 1);
        push_pulse(1, 1);
        push_pulse(3, 1);

        fed      = 0;
        phase_no = 0;
        while (fed < RANDOM_TICKS)
        begin
            if (phase_no < 4)
                mode = setting_e'(phase_no);
            else
            begin
                sel  = $urandom_range(9);
                mode = (sel < 7) ? SET_MIXED : ((sel < 8) ? SET_WIDE : SET_STRAY_INDEX);
            end
            min_v     = 32'($urandom_range(12));
            rpt_v     = 32'($urandom_range(2, 60));
            live_v    = pick_numerator();
            avg_v     = pick_numerator();
            phase_len = $urandom_range(100, 250);
            case (mode)
                SET_EVERY_EDGE:
                begin
                    min_v  = '0;
                    rpt_v  = 32'd1;
                    live_v = '1;
                    avg_v  = '1;
                end
                SET_ALL_GLITCH:
                begin
                    min_v     = '1;
                    rpt_v     = '1;
                    live_v    = 40'd1;
                    avg_v     = 40'd1;
                    phase_len = 40;
                end
                SET_NO_REPORT:
                    rpt_v = '1;
                SET_ZERO_REPORT:
                begin
                    rpt_v  = '0;
                    live_v = 40'd1;
                    avg_v  = '1;
                end
                SET_WIDE:
                begin
                    min_v     = $urandom;
                    rpt_v     = $urandom;
                    phase_len = 40;
                end
                default: ;
            endcase
            push_pause();
            push_write(CFG_MIN_INTERVAL, {8'($urandom), min_v});
            push_write(CFG_REPORT_INTERVAL, {8'($urandom), rpt_v});
            push_write(CFG_LIVE_NUMERATOR, live_v);
            push_write(CFG_AVG_NUMERATOR, avg_v);
            if (mode == SET_STRAY_INDEX)
                push_write(CFG_UNUSED_IDX + 3'($urandom_range(3)), {8'($urandom), 32'($urandom)});

            n = 0;
            while (n < phase_len)
            begin
                sel = $urandom_range(99);
                if (sel < 70)
                begin
                    lo = $urandom_range(1, 10);
                    hi = $urandom_range(1, 6);
                    push_pulse(lo, hi);
                    n += lo + hi;
                end
                else if (sel < 80)
                begin
                    lo = $urandom_range(20, 120);
                    hi = $urandom_range(1, 6);
                    push_pulse(lo, hi);
                    n += lo + hi;
                end
                else if (sel < 95)
                begin
                    push_tick(1'($urandom));
                    n++;
                end
                else
                    push_pause();
            end
            fed += n;
            phase_no++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: ticks, register writes, and pauses that wait for every reading
    always @(posedge clk or negedge rst_n)
    begin : feed
        feed_entry_t              nxt;
        logic                     v_n, l_n, we_n, done_n;
        logic [MPM_CFG_IDX_W-1:0] idx_n;
        logic [MPM_CFG_W-1:0]     dat_n;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_level  <= 1'b0;
            cfg_we    <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
            feed_done <= 1'b0;
            draining = 1'b0;
            settle   = 0;
        end
        else
        begin
            v_n    = in_valid;
            l_n    = in_level;
            we_n   = 1'b0;
            idx_n  = cfg_index;
            dat_n  = cfg_data;
            done_n = feed_done;
            if (in_valid && samples_if.ready)
                v_n = 1'b0;
            // hold the tick until its transfer
            if (!(in_valid && !samples_if.ready))
            begin
                if (draining)
                begin
                    if (readings_owed)
                        settle = SETTLE_CYCLES;
                    else if (settle != 0)
                        settle--;
                    else
                        draining = 1'b0;
                end
                else if (feed_q.size() == 0)
                    done_n = 1'b1;
                else
                begin
                    nxt = feed_q[0];
                    case (nxt.kind)
                        ACT_TICK:
                        begin
                            if (steady || $urandom_range(99) >= IDLE_PCT)
                            begin
                                void'(feed_q.pop_front());
                                v_n = 1'b1;
                                l_n = nxt.level;
                            end
                        end
                        ACT_PAUSE:
                        begin
                            void'(feed_q.pop_front());
                            draining = 1'b1;
                            settle   = SETTLE_CYCLES;
                        end
                        default:
                        begin
                            void'(feed_q.pop_front());
                            we_n  = 1'b1;
                            idx_n = nxt.idx;
                            dat_n = nxt.data;
                        end
                    endcase
                end
            end
            in_valid  <= v_n;
            in_level  <= l_n;
            cfg_we    <= we_n;
            cfg_index <= idx_n;
            cfg_data  <= dat_n;
            feed_done <= done_n;
        end
    end

    // monitor: track register writes, predict on tick transfers, check result transfers
    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t got, want;
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            readings_owed <= 1'b0;
            min_ivl     = RST_MIN_INTERVAL;
            rpt_ivl     = RST_REPORT_INTERVAL;
            live_num    = RST_LIVE_NUMERATOR;
            avg_num     = RST_AVG_NUMERATOR;
            prev_lvl    = 1'b0;
            tick_now    = '0;
            last_edge   = '0;
            last_rpt    = '0;
            blink_cnt   = '0;
            win_cnt     = '0;
            win_ivl_sum = '0;
            win_pwr_sum = '0;
            pending_readings.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_INTERVAL:    min_ivl  = cfg_data[31:0];
                    CFG_REPORT_INTERVAL: rpt_ivl  = cfg_data[31:0];
                    CFG_LIVE_NUMERATOR:  live_num = cfg_data[MPM_NUM_W-1:0];
                    CFG_AVG_NUMERATOR:   avg_num  = cfg_data[MPM_NUM_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && samples_if.ready)
                meter_tick(in_level);
            if (results_if.valid && out_ready)
            begin
                got = {results_if.live_power_w, results_if.blink_total,
                       results_if.interval_ticks, results_if.report_valid,
                       results_if.report_blinks, results_if.avg_interval_ticks,
                       results_if.avg_power_w};
                if (pending_readings.size() == 0)
                    flag_reading("unexpected reading", '0, got);
                else
                begin
                    want = pending_readings.pop_front();
                    if (got !== want)
                        flag_reading("reading mismatch", want, got);
                end
            end
            out_ready     <= steady || ($urandom_range(99) >= IDLE_PCT);
            readings_owed <= (pending_readings.size() != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 32'd1;
        if (cycle_cnt == LIMIT_CYCLES)
        begin
            $display("meter_pulse_power_monitor: mismatch");
            $finish;
        end
    end

    initial
    begin : finish_run
        wait (feed_done);
        while (readings_owed)
            @(posedge clk);
        // catch any late or extra result
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && pending_readings.size() == 0)
            $display("meter_pulse_power_monitor: match");
        else
            $display("meter_pulse_power_monitor: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
